// ===== src/fwwt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Futex wait/wake table package
// Shared entry layout, status codes and timing constants.
// ----------------------------------------------------------------------------
package fwwt_pkg;

   // One stored waiter entry; valid and woken marks are kept in flip-flops.
   typedef struct packed {
      logic [15:0] thread;
      logic [31:0] address;
      logic [31:0] expire;
      logic [31:0] wait_start;
   } entry_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_WAIT       = 3'd1,
      ST_TIMEDOUT   = 3'd2,
      ST_WOULDBLOCK = 3'd3,
      ST_FULL       = 3'd4,
      ST_UNSUP      = 3'd5
   } status_type;

   // Request function codes.
   typedef enum logic [1:0] {
      FUNC_WAIT  = 2'd0,
      FUNC_WAKE  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_UNSUP = 2'd3
   } func_type;

   localparam int unsigned COUNT_W = 6;

   localparam logic [31:0] EXPIRE_INFINITE       = 32'hFFFF_FFFF;
   localparam logic [31:0] EXPIRE_RELATIVE_LIMIT = 32'hF000_0000;

   // ceil(2^50 / 1000000): nanos * NANOS_RECIP >> 50 equals nanos / 1000000
   // for every 30-bit nanos value.
   localparam logic [30:0] NANOS_RECIP = 31'd1125899907;
   localparam int unsigned NANOS_SHIFT = 50;

endpackage

// ===== src/fwwt_entry_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Futex table entry memory
// Single write port and one registered read port holding waiter entries.
// ----------------------------------------------------------------------------
module fwwt_entry_ram #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  fwwt_pkg::entry_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output fwwt_pkg::entry_type        rd_data
);
   import fwwt_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/futex_wait_wake_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Futex wait/wake table
// Keeps a table of waiter entries and serves wait, wake and clear requests by
// scanning it with a shared compare unit, one entry per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake            Items
//   req_      in          req_valid/req_stall  one request
//   rsp_      out         rsp_valid/rsp_stall  1 result, or up to N+1 for wake
//
// Wake and clear scan the whole table and a wait scans until it meets its
// own entry, one entry per cycle through the entry memory read port while
// no wake result is held by a stalled output; unsupported requests skip the
// scan. N is TABLE_ENTRIES. Each result that meets a stalled output adds the
// stall time. Reset empties the table at once by clearing the valid bits.
// req_stall is high from acceptance until the final result is loaded into
// the output register.
// ----------------------------------------------------------------------------
module futex_wait_wake_table #(
   parameter int unsigned TABLE_ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_thread_id,
   input  logic [31:0] req_address,
   input  logic [31:0] req_expected_value,
   input  logic [31:0] req_current_word,
   input  logic        req_has_timeout,
   input  logic [31:0] req_timeout_seconds,
   input  logic [29:0] req_timeout_nanos,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_wake_limit,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_woken_count,
   output logic        rsp_woken_valid,
   output logic [15:0] rsp_woken_thread,
   output logic [31:0] rsp_timer_deadline,
   output logic        rsp_last
);
   import fwwt_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_HIT,
      S_EXP_MUL,
      S_EXP_ADD,
      S_ALLOC,
      S_DONE
   } state_type;

   state_type state_ff;

   // Latched request.
   func_type    func_ff;
   logic [15:0] thread_ff;
   logic [31:0] addr_ff;
   logic        word_ne_ff;
   logic        has_to_ff;
   logic [31:0] secs_ff;
   logic [29:0] nanos_ff;
   logic [31:0] now_ff;
   logic [31:0] limit_ff;

   // Table marks.
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] woken_ff;

   // Scan and resolution state.
   logic [IDX_W-1:0]   eval_idx_ff;
   logic [IDX_W-1:0]   eval_idx_in;
   logic               free_found_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   logic               hit_woken_ff;
   logic [31:0]        hit_expire_ff;
   logic [31:0]        hit_start_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [31:0]        ms_ff;
   logic [60:0]        nprod_ff;
   logic [60:0]        nprod_in;
   logic [31:0]        expire_ff;
   status_type         fin_status_ff;
   logic [31:0]        fin_deadline_ff;

   // Output register.
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_wvalid_ff;
   logic [15:0]        rsp_thread_ff;
   logic [31:0]        rsp_deadline_ff;
   logic               rsp_last_ff;

   // Memory interface.
   entry_type rd_entry;
   entry_type wr_entry;
   logic      wr_en;

   // Shared compare unit and per-entry decisions.
   logic valid_cur;
   logic woken_cur;
   logic addr_eq;
   logic thr_eq;
   logic last_idx;
   logic rsp_free;
   logic wake_cand;
   logic scan_hold;
   logic req_accept;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign valid_cur = valid_ff[eval_idx_ff];
   assign woken_cur = woken_ff[eval_idx_ff];
   assign addr_eq   = (rd_entry.address == addr_ff);
   assign thr_eq    = (rd_entry.thread == thread_ff);
   assign last_idx  = (eval_idx_ff == LAST_IDX);
   assign wake_cand = (func_ff == FUNC_WAKE) && valid_cur && addr_eq && !woken_cur
                      && (32'(count_ff) < limit_ff);
   assign scan_hold = wake_cand && !rsp_free;

   // Next scan index; it also addresses the memory so data lines up with it.
   always_comb begin
      if (state_ff == S_SCAN) begin
         eval_idx_in = scan_hold ? eval_idx_ff : eval_idx_ff + IDX_W'(1);
      end else begin
         eval_idx_in = '0;
      end
   end

   // Nanoseconds to milliseconds by reciprocal multiplication.
   assign nprod_in = 61'(nanos_ff) * 61'(NANOS_RECIP);

   // A new entry is written only when a wait allocates.
   assign wr_en               = (state_ff == S_ALLOC);
   assign wr_entry.thread     = thread_ff;
   assign wr_entry.address    = addr_ff;
   assign wr_entry.expire     = expire_ff;
   assign wr_entry.wait_start = now_ff;

   fwwt_entry_ram #(
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (wr_entry),
      .rd_addr (eval_idx_in),
      .rd_data (rd_entry)
   );

   // Sequencer, table marks and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         eval_idx_ff <= eval_idx_in;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  func_ff       <= func_type'(req_func);
                  thread_ff     <= req_thread_id;
                  addr_ff       <= req_address;
                  word_ne_ff    <= (req_current_word != req_expected_value);
                  has_to_ff     <= req_has_timeout;
                  secs_ff       <= req_timeout_seconds;
                  nanos_ff      <= req_timeout_nanos;
                  now_ff        <= req_now_ms;
                  limit_ff      <= req_wake_limit;
                  free_found_ff <= 1'b0;
                  count_ff      <= '0;
                  if (func_type'(req_func) == FUNC_UNSUP) begin
                     fin_status_ff   <= ST_UNSUP;
                     fin_deadline_ff <= '0;
                     state_ff        <= S_DONE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end

            S_SCAN: begin
               case (func_ff)
                  FUNC_WAIT: begin
                     if (valid_cur && addr_eq && thr_eq) begin
                        // Existing entry for this thread and address.
                        hit_idx_ff    <= eval_idx_ff;
                        hit_woken_ff  <= woken_cur;
                        hit_expire_ff <= rd_entry.expire;
                        hit_start_ff  <= rd_entry.wait_start;
                        state_ff      <= S_HIT;
                     end else begin
                        // Remember the lowest free entry on the way.
                        if (!valid_cur && !free_found_ff) begin
                           free_found_ff <= 1'b1;
                           free_idx_ff   <= eval_idx_ff;
                        end
                        if (last_idx) begin
                           fin_deadline_ff <= '0;
                           if (word_ne_ff) begin
                              fin_status_ff <= ST_WOULDBLOCK;
                              state_ff      <= S_DONE;
                           end else if (!free_found_ff && valid_cur) begin
                              fin_status_ff <= ST_FULL;
                              state_ff      <= S_DONE;
                           end else if (!has_to_ff) begin
                              expire_ff <= EXPIRE_INFINITE;
                              state_ff  <= S_ALLOC;
                           end else begin
                              state_ff <= S_EXP_MUL;
                           end
                        end
                     end
                  end

                  FUNC_WAKE: begin
                     // Wake one matching entry per cycle while the output is free.
                     if (wake_cand && rsp_free) begin
                        woken_ff[eval_idx_ff] <= 1'b1;
                        count_ff              <= count_ff + COUNT_W'(1);
                        rsp_valid_ff          <= 1'b1;
                        rsp_status_ff         <= ST_OK;
                        rsp_count_ff          <= '0;
                        rsp_wvalid_ff         <= 1'b1;
                        rsp_thread_ff         <= rd_entry.thread;
                        rsp_deadline_ff       <= '0;
                        rsp_last_ff           <= 1'b0;
                     end
                     if (!scan_hold && last_idx) begin
                        fin_status_ff   <= ST_OK;
                        fin_deadline_ff <= '0;
                        state_ff        <= S_DONE;
                     end
                  end

                  default: begin
                     // Clear frees every entry of the thread.
                     if (valid_cur && thr_eq) begin
                        valid_ff[eval_idx_ff] <= 1'b0;
                     end
                     if (last_idx) begin
                        fin_status_ff   <= ST_OK;
                        fin_deadline_ff <= '0;
                        state_ff        <= S_DONE;
                     end
                  end
               endcase
            end

            S_HIT: begin
               // Resolve the existing entry: woken, expired or still waiting.
               if (hit_woken_ff) begin
                  valid_ff[hit_idx_ff] <= 1'b0;
                  fin_status_ff        <= ST_OK;
                  fin_deadline_ff      <= '0;
               end else if (hit_expire_ff <= now_ff) begin
                  valid_ff[hit_idx_ff] <= 1'b0;
                  fin_status_ff        <= ST_TIMEDOUT;
                  fin_deadline_ff      <= '0;
               end else begin
                  fin_status_ff   <= ST_WAIT;
                  fin_deadline_ff <= (hit_expire_ff < EXPIRE_RELATIVE_LIMIT) ?
                                     hit_expire_ff + hit_start_ff : hit_expire_ff;
               end
               state_ff <= S_DONE;
            end

            S_EXP_MUL: begin
               // Seconds times 1000 as 1024 - 16 - 8.
               ms_ff    <= (secs_ff << 10) - (secs_ff << 4) - (secs_ff << 3);
               nprod_ff <= nprod_in;
               state_ff <= S_EXP_ADD;
            end

            S_EXP_ADD: begin
               expire_ff <= ms_ff + 32'(nprod_ff[60:NANOS_SHIFT]) + now_ff;
               state_ff  <= S_ALLOC;
            end

            S_ALLOC: begin
               // The memory write of the new entry happens in this cycle.
               valid_ff[free_idx_ff] <= 1'b1;
               woken_ff[free_idx_ff] <= 1'b0;
               fin_status_ff         <= ST_WAIT;
               fin_deadline_ff       <= (expire_ff < EXPIRE_RELATIVE_LIMIT) ?
                                        expire_ff + now_ff : expire_ff;
               state_ff              <= S_DONE;
            end

            S_DONE: begin
               // Final result of the request.
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= fin_status_ff;
                  rsp_count_ff    <= count_ff;
                  rsp_wvalid_ff   <= 1'b0;
                  rsp_thread_ff   <= '0;
                  rsp_deadline_ff <= fin_deadline_ff;
                  rsp_last_ff     <= 1'b1;
                  state_ff        <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_woken_count    = rsp_count_ff;
   assign rsp_woken_valid    = rsp_wvalid_ff;
   assign rsp_woken_thread   = rsp_thread_ff;
   assign rsp_timer_deadline = rsp_deadline_ff;
   assign rsp_last           = rsp_last_ff;

endmodule
